[src/max_pool_2d_window_top_defines.svh]
// Assertion macros shared by the max pooling block.
// No dependencies; included by the modules that carry assertions.
`ifndef MAX_POOL_2D_WINDOW_TOP_DEFINES_SVH
`define MAX_POOL_2D_WINDOW_TOP_DEFINES_SVH

`ifndef SYNTH
// condition holds at every edge out of reset
`define MP2W_ASSERT_ALWAYS(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");
// same-cycle implication
`define MP2W_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define MP2W_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MP2W_ASSERT_ALWAYS(label, clk, rst_n, cond)
`define MP2W_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define MP2W_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[src/mp2w_pkg.sv]
`timescale 1ns / 1ps
// Package for the max pooling block: sizes, field widths, codes and the
// controller/datapath command and status structs. No dependencies.
package mp2w_pkg;

  localparam int MAX_HEIGHT = 64;
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_WINDOW = 8;

  // field widths
  localparam int COORD_W   = 6;
  localparam int VALUE_W   = 16;
  localparam int DIM_W     = 7;
  localparam int WCFG_W    = 4;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DAT_W = 7;

  // derived sizes
  localparam int ADDR_W = $clog2(MAX_HEIGHT * MAX_WIDTH);
  localparam int WIN_W  = $clog2(MAX_WINDOW + 1);
  localparam int CNT_W  = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int POS_W  = COORD_W + WCFG_W + 1;
  localparam int LIM_W  = ($clog2(MAX_HEIGHT + 1) > $clog2(MAX_WIDTH + 1)) ?
                          $clog2(MAX_HEIGHT + 1) : $clog2(MAX_WIDTH + 1);

  // request codes
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_QUERY = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP   = 4'd3;

  localparam logic signed [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef struct packed {
    logic write_en;
    logic query_load;
    logic scan_step;
  } mp2w_cmd_t;

  typedef struct packed {
    logic win_zero;
    logic scan_last;
  } mp2w_sts_t;

endpackage

[src/mp2w_if.sv]
`timescale 1ns / 1ps
// Channel interfaces of the max pooling block: request, result and config write.
// Depends on mp2w_pkg.
interface mp2w_req_if
  import mp2w_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic                      req_type;
  logic [COORD_W-1:0]        pixel_row;
  logic [COORD_W-1:0]        pixel_col;
  logic signed [VALUE_W-1:0] pixel_value;
  logic [COORD_W-1:0]        out_row;
  logic [COORD_W-1:0]        out_col;

  modport source (output valid, req_type, pixel_row, pixel_col, pixel_value,
                  out_row, out_col, input ready);
  modport sink (input valid, req_type, pixel_row, pixel_col, pixel_value,
                out_row, out_col, output ready);
endinterface

interface mp2w_rsp_if
  import mp2w_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] max_value;
  logic                      any_in_range;

  modport source (output valid, max_value, any_in_range, input ready);
  modport sink (input valid, max_value, any_in_range, output ready);
endinterface

interface mp2w_cfg_if
  import mp2w_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_idx;
  logic [CFG_DAT_W-1:0] wr_data;

  modport source (output valid, reg_idx, wr_data, input ready);
  modport sink (input valid, reg_idx, wr_data, output ready);
endinterface

[src/mp2w_datapath.sv]
`timescale 1ns / 1ps
// Datapath of the max pooling block: config registers, plane store, window
// counters and running maximum. Depends on mp2w_pkg.
module mp2w_datapath
  import mp2w_pkg::*;
(
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mp2w_cmd_t                 cmd_i,
  output mp2w_sts_t                 sts_o,
  input  logic                      cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [CFG_DAT_W-1:0]      cfg_data_i,
  input  logic [COORD_W-1:0]        pixel_row_i,
  input  logic [COORD_W-1:0]        pixel_col_i,
  input  logic signed [VALUE_W-1:0] pixel_value_i,
  input  logic [COORD_W-1:0]        out_row_i,
  input  logic [COORD_W-1:0]        out_col_i,
  output logic signed [VALUE_W-1:0] max_value_o,
  output logic                      any_in_range_o
);

  logic [DIM_W-1:0]  height_q, width_q;
  logic [WCFG_W-1:0] win_q, step_q;

  logic [LIM_W-1:0] h_lim, w_lim;
  logic [WIN_W-1:0] win_eff;

  logic [POS_W-1:0] r0_q, c0_q;
  logic [CNT_W-1:0] i_q, j_q;
  logic [POS_W-1:0] pos_h, pos_w;
  logic             i_last, j_last, in_rng;

  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic              wr_en;

  logic signed [VALUE_W-1:0] mem [MAX_HEIGHT*MAX_WIDTH];
  logic signed [VALUE_W-1:0] rd_data_q;
  logic                      rd_valid_q;
  logic signed [VALUE_W-1:0] best_q;
  logic                      any_q;

  // saturate plane size and window to the store limits
  assign h_lim = (32'(height_q) > MAX_HEIGHT) ? LIM_W'(MAX_HEIGHT) : LIM_W'(height_q);
  assign w_lim = (32'(width_q) > MAX_WIDTH) ? LIM_W'(MAX_WIDTH) : LIM_W'(width_q);
  assign win_eff = (32'(win_q) > MAX_WINDOW) ? WIN_W'(MAX_WINDOW) : WIN_W'(win_q);

  assign pos_h  = r0_q + POS_W'(i_q);
  assign pos_w  = c0_q + POS_W'(j_q);
  assign i_last = (WIN_W'(i_q) == win_eff - WIN_W'(1));
  assign j_last = (WIN_W'(j_q) == win_eff - WIN_W'(1));
  assign in_rng = cmd_i.scan_step && (pos_h < POS_W'(h_lim)) && (pos_w < POS_W'(w_lim));

  assign rd_addr = ADDR_W'(ADDR_W'(pos_h) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(pos_w);
  assign wr_addr = ADDR_W'(ADDR_W'(pixel_row_i) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(pixel_col_i);
  assign wr_en   = cmd_i.write_en && (32'(pixel_row_i) < MAX_HEIGHT) &&
                   (32'(pixel_col_i) < MAX_WIDTH);

  assign sts_o.win_zero  = (win_q == '0);
  assign sts_o.scan_last = i_last && j_last;

  assign max_value_o    = best_q;
  assign any_in_range_o = any_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= DIM_W'(64);
      width_q  <= DIM_W'(64);
      win_q    <= WCFG_W'(2);
      step_q   <= WCFG_W'(2);
    end else if (cfg_valid_i) begin
      case (cfg_idx_i)
        CFG_HEIGHT: height_q <= cfg_data_i[DIM_W-1:0];
        CFG_WIDTH:  width_q  <= cfg_data_i[DIM_W-1:0];
        CFG_WINDOW: win_q    <= cfg_data_i[WCFG_W-1:0];
        CFG_STEP:   step_q   <= cfg_data_i[WCFG_W-1:0];
        default: ;
      endcase
    end
  end

  // window origin and scan counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      j_q <= '0;
    end else if (cmd_i.query_load) begin
      i_q <= '0;
      j_q <= '0;
    end else if (cmd_i.scan_step) begin
      if (j_last) begin
        j_q <= '0;
        i_q <= i_q + CNT_W'(1);
      end else begin
        j_q <= j_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.query_load) begin
      r0_q <= POS_W'(POS_W'(out_row_i) * POS_W'(step_q));
      c0_q <= POS_W'(POS_W'(out_col_i) * POS_W'(step_q));
    end
  end

  // plane store, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= pixel_value_i;
    end
    if (in_rng) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  // running maximum, one compare per read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
      any_q      <= 1'b0;
      best_q     <= VALUE_MIN;
    end else begin
      rd_valid_q <= in_rng;
      if (cmd_i.query_load) begin
        any_q  <= 1'b0;
        best_q <= VALUE_MIN;
      end else if (rd_valid_q) begin
        if (!any_q || (rd_data_q > best_q)) begin
          best_q <= rd_data_q;
        end
        any_q <= 1'b1;
      end
    end
  end

endmodule

[src/mp2w_ctrl.sv]
`timescale 1ns / 1ps
// Controller of the max pooling block: sequences one transaction at a time and
// drives the handshakes. Depends on mp2w_pkg and the assertion macro header.
`include "max_pool_2d_window_top_defines.svh"

module mp2w_ctrl
  import mp2w_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  input  logic      req_type_i,
  output logic      req_ready_o,
  output logic      rsp_valid_o,
  input  logic      rsp_ready_i,
  input  mp2w_sts_t sts_i,
  output mp2w_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_RESULT
  } state_e;

  state_e state_q;
  logic   in_ready_q;
  logic   out_valid_q;
  logic   in_fire;

  assign in_fire = req_valid_i && in_ready_q;

  assign cmd_o.write_en   = in_fire && (req_type_i == REQ_WRITE);
  assign cmd_o.query_load = in_fire && (req_type_i == REQ_QUERY);
  assign cmd_o.scan_step  = (state_q == ST_SCAN);

  assign req_ready_o = in_ready_q;
  assign rsp_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      in_ready_q  <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_fire && (req_type_i == REQ_QUERY)) begin
            in_ready_q <= 1'b0;
            if (sts_i.win_zero) begin
              state_q     <= ST_RESULT;
              out_valid_q <= 1'b1;
            end else begin
              state_q <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (sts_i.scan_last) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          // last read compares this cycle
          state_q     <= ST_RESULT;
          out_valid_q <= 1'b1;
        end
        ST_RESULT: begin
          if (rsp_ready_i) begin
            state_q     <= ST_IDLE;
            out_valid_q <= 1'b0;
            in_ready_q  <= 1'b1;
          end
        end
        default: begin
          state_q     <= ST_IDLE;
          in_ready_q  <= 1'b1;
          out_valid_q <= 1'b0;
        end
      endcase
    end
  end

  `MP2W_ASSERT_ALWAYS(a_ready_xor_result, clk_i, rst_ni, !(in_ready_q && out_valid_q))
  `MP2W_ASSERT_IMPLY(a_ready_only_idle, clk_i, rst_ni, in_ready_q, state_q == ST_IDLE)
  `MP2W_ASSERT_NEXT(a_query_starts_scan, clk_i, rst_ni, cmd_o.query_load && !sts_i.win_zero, state_q == ST_SCAN)
  `MP2W_ASSERT_NEXT(a_scan_ends, clk_i, rst_ni, (state_q == ST_SCAN) && sts_i.scan_last, state_q == ST_DRAIN)
  `MP2W_ASSERT_NEXT(a_drain_to_result, clk_i, rst_ni, state_q == ST_DRAIN, out_valid_q)

endmodule

[src/max_pool_2d_window_top.sv]
`timescale 1ns / 1ps
// Top level of the 2-D max pooling block: controller plus datapath.
// Depends on mp2w_pkg, the channel interfaces, mp2w_ctrl and mp2w_datapath.
//
//  channel  dir  handshake        payload
//  req_i    in   valid/ready      req_type, pixel_row/col/value, out_row/col
//  rsp_o    out  valid/ready      max_value, any_in_range
//  cfg_i    in   valid/ready(=1)  reg_idx, wr_data
//
// A write transaction completes on accept; ready stays high after it.
// A query with window w (saturated to 8) scans the store one entry per cycle over
// its single read port, then drains the last read before the result is valid; a
// zero window skips the scan and gives the result in the cycle after accept.
// Ready is low from a query's accept until its result is taken; a stalled result
// simply holds. Reset loads plane 64x64, window 2, stride 2; the store is not cleared.
module max_pool_2d_window_top
  import mp2w_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  mp2w_req_if.sink   req_i,
  mp2w_rsp_if.source rsp_o,
  mp2w_cfg_if.sink   cfg_i
);

  mp2w_cmd_t cmd;
  mp2w_sts_t sts;

  assign cfg_i.ready = 1'b1;

  mp2w_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_type_i  (req_i.req_type),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mp2w_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_valid_i    (cfg_i.valid),
    .cfg_idx_i      (cfg_i.reg_idx),
    .cfg_data_i     (cfg_i.wr_data),
    .pixel_row_i    (req_i.pixel_row),
    .pixel_col_i    (req_i.pixel_col),
    .pixel_value_i  (req_i.pixel_value),
    .out_row_i      (req_i.out_row),
    .out_col_i      (req_i.out_col),
    .max_value_o    (rsp_o.max_value),
    .any_in_range_o (rsp_o.any_in_range)
  );

endmodule

[verif/mp2w_pool_checker.sv]
`timescale 1ns / 1ps
// Scoreboard for the max pooling block: mirrors the pixel store and registers,
// predicts each pooled result and compares it. Depends on mp2w_pkg and mp2w_if.
module mp2w_pool_checker
  import mp2w_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  mp2w_req_if  req_mon,
  mp2w_rsp_if  rsp_mon,
  mp2w_cfg_if  cfg_mon,
  output int   pending_o,
  output int   fail_count_o
);

  typedef struct packed {
    logic [VALUE_W-1:0] max_value;
    logic               any_in_range;
  } pool_result_t;

  logic signed [VALUE_W-1:0] plane_mirror [MAX_HEIGHT*MAX_WIDTH];
  logic [DIM_W-1:0]          rows_cfg;
  logic [DIM_W-1:0]          cols_cfg;
  logic [WCFG_W-1:0]         side_cfg;
  logic [WCFG_W-1:0]         step_cfg;
  pool_result_t              pooled_q [$];
  int                        mismatch_count = 0;

  assign fail_count_o = mismatch_count;

  function automatic pool_result_t pool_window(logic [COORD_W-1:0] orow,
                                               logic [COORD_W-1:0] ocol);
    pool_result_t              res;
    logic signed [VALUE_W-1:0] best;
    logic signed [VALUE_W-1:0] pix;
    logic                      hit;
    int                        row_lim, col_lim, side, r0, c0, i, j;
    row_lim = (rows_cfg > MAX_HEIGHT) ? MAX_HEIGHT : int'(rows_cfg);
    col_lim = (cols_cfg > MAX_WIDTH) ? MAX_WIDTH : int'(cols_cfg);
    side    = (side_cfg > MAX_WINDOW) ? MAX_WINDOW : int'(side_cfg);
    r0      = int'(orow) * int'(step_cfg);
    c0      = int'(ocol) * int'(step_cfg);
    best    = VALUE_MIN;
    hit     = 1'b0;
    for (i = 0; i < side; i++) begin
      for (j = 0; j < side; j++) begin
        if (r0 + i < row_lim && c0 + j < col_lim) begin
          pix = plane_mirror[(r0 + i) * MAX_WIDTH + c0 + j];
          if (!hit || pix > best) best = pix;
          hit = 1'b1;
        end
      end
    end
    res.max_value    = best;
    res.any_in_range = hit;
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d, expected %0d (t=%0t)", what, got, want, $realtime);
    mismatch_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pool_result_t want;
    if (!rst_ni) begin
      rows_cfg = DIM_W'(MAX_HEIGHT);
      cols_cfg = DIM_W'(MAX_WIDTH);
      side_cfg = WCFG_W'(2);
      step_cfg = WCFG_W'(2);
      pooled_q.delete();
      pending_o <= 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (pooled_q.size() == 0) begin
          report_mismatch("result transaction with no query outstanding",
                          int'($signed(rsp_mon.max_value)), 0);
        end else begin
          want = pooled_q.pop_front();
          if (rsp_mon.max_value !== want.max_value)
            report_mismatch("max_value", int'($signed(rsp_mon.max_value)),
                            int'($signed(want.max_value)));
          if (rsp_mon.any_in_range !== want.any_in_range)
            report_mismatch("any_in_range", int'(rsp_mon.any_in_range),
                            int'(want.any_in_range));
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.reg_idx)
          CFG_HEIGHT: rows_cfg = cfg_mon.wr_data;
          CFG_WIDTH:  cols_cfg = cfg_mon.wr_data;
          CFG_WINDOW: side_cfg = cfg_mon.wr_data[WCFG_W-1:0];
          CFG_STEP:   step_cfg = cfg_mon.wr_data[WCFG_W-1:0];
          default: ;
        endcase
      end
      if (req_mon.valid && req_mon.ready) begin
        if (req_mon.req_type == REQ_WRITE)
          plane_mirror[{req_mon.pixel_row, req_mon.pixel_col}] = req_mon.pixel_value;
        else
          pooled_q.push_back(pool_window(req_mon.out_row, req_mon.out_col));
      end
      pending_o <= pooled_q.size();
    end
  end

endmodule

[verif/tb_max_pool_2d_window_top.sv]
`timescale 1ns / 1ps
// Testbench top for max_pool_2d_window_top: drives pixel writes, pooling queries
// and register writes, and gives the verdict. Depends on mp2w_pkg, mp2w_if, the checker.
module tb_max_pool_2d_window_top;
  import mp2w_pkg::*;

  localparam int NUM_PHASES      = 20;
  localparam int NUM_FIXED       = 12;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int LONG_HOLD       = 400;
  localparam int WRITE_SETTLE    = 4;
  localparam int END_SETTLE      = 80;
  localparam int CYCLE_LIMIT     = 3000000;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LAST = '1;

  logic clk_i = 1'b0;
  logic rst_ni;

  mp2w_req_if req_if ();
  mp2w_rsp_if rsp_if ();
  mp2w_cfg_if cfg_if ();

  int outstanding;
  int fail_count;

  max_pool_2d_window_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  mp2w_pool_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_if),
    .rsp_mon      (rsp_if),
    .cfg_mon      (cfg_if),
    .pending_o    (outstanding),
    .fail_count_o (fail_count)
  );

  // height, width, window, stride; zero and oversized values saturate or empty
  int fixed_cfg [NUM_FIXED][4] = '{
    '{8, 8, 3, 2}, '{0, 10, 2, 1}, '{10, 0, 3, 1}, '{5, 7, 0, 1},
    '{127, 127, 15, 3}, '{9, 9, 3, 0}, '{1, 1, 1, 1}, '{64, 64, 8, 8},
    '{64, 64, 8, 1}, '{13, 6, 4, 3}, '{3, 17, 5, 7}, '{64, 64, 2, 2}
  };

  bit               written_map [MAX_HEIGHT*MAX_WIDTH];
  logic [DIM_W-1:0] cur_rows;
  logic [DIM_W-1:0] cur_cols;
  logic [WCFG_W-1:0] cur_side;
  logic [WCFG_W-1:0] cur_step;
  bit               tx_idle_on;
  bit               rx_idle_on;
  int               hold_requests = 0;
  int               hold_served = 0;
  int               cycle_count = 0;
  int               writes_sent = 0;
  int               queries_sent = 0;
  int               settings_used = 1;

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count, outstanding);
      $display("tb_max_pool_2d_window_top failed");
      $finish;
    end
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return $urandom_range(1, 2);
    if (roll < 95) return $urandom_range(3, 6);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 19))
      0: return VALUE_MIN;
      1: return 16'h7FFF;
      2: return '0;
      3: return '1;
      default: return VALUE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  // receiver: random stalls plus one long hold-off on request
  initial begin
    int stall_left;
    stall_left = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        stall_left = LONG_HOLD - 1;
        rsp_if.ready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 99) < 30) begin
        stall_left = pick_gap() - 1;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  task automatic send_req(logic req_type, logic [COORD_W-1:0] prow,
                          logic [COORD_W-1:0] pcol, logic [VALUE_W-1:0] pval,
                          logic [COORD_W-1:0] orow, logic [COORD_W-1:0] ocol);
    req_if.valid       <= 1'b1;
    req_if.req_type    <= req_type;
    req_if.pixel_row   <= prow;
    req_if.pixel_col   <= pcol;
    req_if.pixel_value <= pval;
    req_if.out_row     <= orow;
    req_if.out_col     <= ocol;
    do @(posedge clk_i); while (!req_if.ready);
    if (req_type == REQ_WRITE) begin
      written_map[{prow, pcol}] = 1'b1;
      writes_sent++;
    end else begin
      queries_sent++;
    end
    if (tx_idle_on && $urandom_range(0, 99) < 30) begin
      req_if.valid <= 1'b0;
      repeat (pick_gap()) @(posedge clk_i);
    end
  endtask

  task automatic put_pixel(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
                           logic [VALUE_W-1:0] val);
    send_req(REQ_WRITE, row, col, val, COORD_W'($urandom_range(0, 63)),
             COORD_W'($urandom_range(0, 63)));
  endtask

  // write every in-plane window position not yet loaded, then query
  task automatic ask_pool(logic [COORD_W-1:0] orow, logic [COORD_W-1:0] ocol);
    int row_lim, col_lim, side, r0, c0, i, j;
    row_lim = (cur_rows > MAX_HEIGHT) ? MAX_HEIGHT : int'(cur_rows);
    col_lim = (cur_cols > MAX_WIDTH) ? MAX_WIDTH : int'(cur_cols);
    side    = (cur_side > MAX_WINDOW) ? MAX_WINDOW : int'(cur_side);
    r0      = int'(orow) * int'(cur_step);
    c0      = int'(ocol) * int'(cur_step);
    for (i = 0; i < side; i++)
      for (j = 0; j < side; j++)
        if (r0 + i < row_lim && c0 + j < col_lim &&
            !written_map[(r0 + i) * MAX_WIDTH + c0 + j])
          put_pixel(COORD_W'(r0 + i), COORD_W'(c0 + j), pick_value());
    send_req(REQ_QUERY, COORD_W'($urandom_range(0, 63)), COORD_W'($urandom_range(0, 63)),
             VALUE_W'($urandom_range(0, 65535)), orow, ocol);
  endtask

  task automatic drain_results();
    req_if.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    cfg_if.valid   <= 1'b1;
    cfg_if.reg_idx <= idx;
    cfg_if.wr_data <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      CFG_HEIGHT: cur_rows = data;
      CFG_WIDTH:  cur_cols = data;
      CFG_WINDOW: cur_side = data[WCFG_W-1:0];
      CFG_STEP:   cur_step = data[WCFG_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(int rows, int cols, int side, int step);
    drain_results();
    repeat (WRITE_SETTLE) @(posedge clk_i);
    write_reg(CFG_HEIGHT, CFG_DAT_W'(rows));
    write_reg(CFG_WIDTH, CFG_DAT_W'(cols));
    write_reg(CFG_WINDOW, CFG_DAT_W'(side));
    write_reg(CFG_STEP, CFG_DAT_W'(step));
    // unmapped indexes must leave the settings alone
    if ($urandom_range(0, 99) < 30)
      write_reg(CFG_IDX_W'($urandom_range(int'(CFG_STEP) + 1, int'(CFG_IDX_LAST))),
                CFG_DAT_W'($urandom_range(0, 127)));
    cfg_if.valid <= 1'b0;
    settings_used++;
  endtask

  function automatic int pick_dim();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return $urandom_range(1, 16);
    if (roll < 80) return $urandom_range(17, 64);
    return $urandom_range(0, 127);
  endfunction

  function automatic int pick_side();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return $urandom_range(1, 4);
    if (roll < 85) return $urandom_range(5, 8);
    return $urandom_range(0, 127);
  endfunction

  // output coordinate biased toward windows that touch the plane
  function automatic logic [COORD_W-1:0] pick_out_coord(logic [DIM_W-1:0] dim);
    int lim, top;
    lim = (dim > MAX_HEIGHT) ? MAX_HEIGHT : int'(dim);
    if (cur_step == 0 || lim == 0 || $urandom_range(0, 99) < 15)
      return COORD_W'($urandom_range(0, 63));
    top = (lim - 1) / int'(cur_step) + 1;
    if (top > 63) top = 63;
    return COORD_W'($urandom_range(0, top));
  endfunction

  function automatic logic [COORD_W-1:0] pick_pixel_coord(logic [DIM_W-1:0] dim);
    if (dim == 0 || $urandom_range(0, 99) < 40) return COORD_W'($urandom_range(0, 63));
    return COORD_W'($urandom_range(0, (dim > MAX_HEIGHT) ? 63 : int'(dim) - 1));
  endfunction

  // budget counts window fill writes too
  task automatic run_random(int count);
    int start;
    start = writes_sent + queries_sent;
    while (writes_sent + queries_sent - start < count) begin
      if ($urandom_range(0, 99) < 35)
        put_pixel(pick_pixel_coord(cur_rows), pick_pixel_coord(cur_cols), pick_value());
      else
        ask_pool(pick_out_coord(cur_rows), pick_out_coord(cur_cols));
      if ($urandom_range(0, 99) < 2) drain_results();
    end
  endtask

  initial begin
    int p;
    rst_ni             = 1'b0;
    req_if.valid       = 1'b0;
    req_if.req_type    = REQ_WRITE;
    req_if.pixel_row   = '0;
    req_if.pixel_col   = '0;
    req_if.pixel_value = '0;
    req_if.out_row     = '0;
    req_if.out_col     = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.reg_idx     = CFG_HEIGHT;
    cfg_if.wr_data     = '0;
    cur_rows           = DIM_W'(MAX_HEIGHT);
    cur_cols           = DIM_W'(MAX_WIDTH);
    cur_side           = WCFG_W'(2);
    cur_step           = WCFG_W'(2);
    tx_idle_on         = 1'b0;
    rx_idle_on         = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: value extremes, plane corners, windows past the plane edge
    put_pixel(0, 0, VALUE_MIN);
    put_pixel(0, 1, VALUE_MIN);
    put_pixel(1, 0, VALUE_MIN);
    put_pixel(1, 1, VALUE_MIN);
    ask_pool(0, 0);
    put_pixel(62, 62, 16'h7FFF);
    put_pixel(62, 63, '1);
    put_pixel(63, 62, '0);
    put_pixel(63, 63, 16'h0001);
    ask_pool(31, 31);
    put_pixel(1, 1, 16'h0005);
    ask_pool(0, 0);
    ask_pool(32, 0);
    ask_pool(0, 63);
    ask_pool(63, 63);
    ask_pool(31, 0);

    for (p = 0; p < NUM_PHASES; p++) begin
      if (p < NUM_FIXED)
        apply_settings(fixed_cfg[p][0], fixed_cfg[p][1], fixed_cfg[p][2], fixed_cfg[p][3]);
      else
        apply_settings(pick_dim(), pick_dim(), pick_side(), pick_side());
      tx_idle_on = (p % 3) != 1;
      rx_idle_on = (p % 4) != 2;
      // long receiver hold while the sender keeps offering
      if (p == 2 || p == 14) hold_requests++;
      run_random(ITEMS_PER_PHASE);
    end

    drain_results();
    repeat (END_SETTLE) @(posedge clk_i);
    $display("Covered %0d pixel writes and %0d pooling queries over %0d register settings,",
             writes_sent, queries_sent, settings_used);
    $display("with empty, saturated and zero-stride windows and long result back-pressure.");
    if (fail_count == 0 && outstanding == 0) begin
      $display("tb_max_pool_2d_window_top passed");
    end else begin
      $display("%0d mismatches, %0d results never seen", fail_count, outstanding);
      $display("tb_max_pool_2d_window_top failed");
    end
    $finish;
  end

endmodule

[max_pool_2d_window_top.f]
+incdir+src
src/mp2w_pkg.sv
src/mp2w_if.sv
src/mp2w_datapath.sv
src/mp2w_ctrl.sv
src/max_pool_2d_window_top.sv
verif/mp2w_pool_checker.sv
verif/tb_max_pool_2d_window_top.sv
